FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL; all sample on clk and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/wsg_pkg.sv
// ----------------------------------------------------------------------------
// wsg_pkg
// Types and constants shared by the wavetable generator controller and datapath.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int NumCh    = 5;
    localparam int ChW      = 3;
    localparam int CntW     = 15;   // phase count plus tick increment
    localparam int PhaseW   = 14;
    localparam int PerW     = 12;
    localparam int SumW     = 17;
    localparam int DivBits  = CntW;
    localparam int DivCntW  = 4;

    localparam logic [ChW-1:0]   LastCh     = 3'd4;
    localparam logic [8:0]       WaveRegion = 9'h130;   // 0x9800 >> 7
    localparam logic [10:0]      CtrlRegion = 11'h4C4;  // 0x9880 >> 5
    localparam logic [10:0]      DefRegion  = 11'h4C7;  // 0x98E0 >> 5
    localparam logic [11:0]      TpsReset   = 12'd81;
    localparam logic [3:0]       VolBase    = 4'hA;
    localparam logic [3:0]       EnableReg  = 4'hF;
    localparam logic [7:0]       WaveReset  = 8'hFF;

    typedef struct packed {
        logic           capture;
        logic           bus_wr;
        logic           clr_sum;
        logic           load;
        logic           div_step;
        logic           update;
        logic           rd;
        logic           mac;
        logic           publish;
        logic [ChW-1:0] ch;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
        logic need_div;
    } dp_sts_t;

endpackage

FILE: src/wsg_ctrl.sv
// ----------------------------------------------------------------------------
// wsg_ctrl
// Sequencer: walks bus writes and the five channels of each sample tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  logic                m_tready,
    output logic                m_tvalid,
    output wsg_pkg::ctrl_cmd_t  cmd,
    input  wsg_pkg::dp_sts_t    sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_LOAD, S_DIV, S_UPDATE, S_READ, S_MAC, S_PUBLISH
    } state_t;

    state_t                         state_reg, state_next;
    logic [wsg_pkg::ChW-1:0]        ch_reg, ch_next;
    logic [wsg_pkg::DivCntW-1:0]    div_cnt_reg, div_cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           accept;
    logic                           out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd          = '0;
        cmd.ch       = ch_reg;
        cmd.capture  = accept;
        cmd.clr_sum  = accept && s_tuser;
        cmd.bus_wr   = (state_reg == S_WRITE);
        cmd.load     = (state_reg == S_LOAD);
        cmd.div_step = (state_reg == S_DIV);
        cmd.update   = (state_reg == S_UPDATE);
        cmd.rd       = (state_reg == S_READ);
        cmd.mac      = (state_reg == S_MAC);
        cmd.publish  = (state_reg == S_PUBLISH) && out_free;
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = '0;
                    state_next = s_tuser ? S_LOAD : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_LOAD:
            begin
                div_cnt_next = '0;
                if (!sts.active)
                begin
                    if (ch_reg == wsg_pkg::LastCh)
                    begin
                        state_next = S_PUBLISH;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
                else if (sts.need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == wsg_pkg::DivCntW'(wsg_pkg::DivBits - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (ch_reg == wsg_pkg::LastCh)
                begin
                    state_next = S_PUBLISH;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_PUBLISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ch_reg       <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `ASSERT_ALWAYS(a_ch_range, ch_reg <= wsg_pkg::LastCh)
    `ASSERT_IMPLIES(a_div_bound, state_reg == S_DIV,
        div_cnt_reg < wsg_pkg::DivCntW'(wsg_pkg::DivBits))
    `ASSERT_IMPLIES(a_publish_free, cmd.publish, !m_tvalid_reg || m_tready)

endmodule

FILE: src/wsg_datapath.sv
// ----------------------------------------------------------------------------
// wsg_datapath
// Channel registers, wave memory, shared restoring divider and mix accumulator.
// ----------------------------------------------------------------------------
module wsg_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [23:0]                 s_tdata,
    input  logic                        cfg_we,
    input  logic [11:0]                 cfg_wdata,
    input  wsg_pkg::ctrl_cmd_t          cmd,
    output wsg_pkg::dp_sts_t            sts,
    output logic [wsg_pkg::SumW-1:0]    sample
);

    localparam int NumCh = wsg_pkg::NumCh;

    logic [15:0]                 addr_reg;
    logic [7:0]                  data_reg;
    logic [11:0]                 tps_reg;
    logic [wsg_pkg::PerW-1:0]    per_reg   [NumCh];
    logic [5:0]                  vol_reg   [NumCh];
    logic [4:0]                  pos_reg   [NumCh];
    logic [wsg_pkg::PhaseW-1:0]  phase_reg [NumCh];
    logic [7:0]                  enable_reg;
    logic [7:0]                  deform_reg;
    logic [7:0]                  wave_mem  [128];
    logic [127:0]                wave_vld_reg;
    logic [7:0]                  rdata_reg;
    logic                        rvld_reg;
    logic [wsg_pkg::CntW-1:0]    cnt_reg;
    logic [wsg_pkg::CntW-1:0]    quo_reg;
    logic [wsg_pkg::PerW-1:0]    rem_reg;
    logic                        div_used_reg;
    logic [wsg_pkg::SumW-1:0]    sum_reg;
    logic [wsg_pkg::SumW-1:0]    out_reg;

    logic [wsg_pkg::CntW-1:0]    cnt_sum;
    logic [wsg_pkg::PerW:0]      shifted;
    logic                        sub_ok;
    logic [wsg_pkg::PerW-1:0]    cur_per;
    logic [6:0]                  rd_addr;
    logic [7:0]                  wave_byte;
    logic [13:0]                 product;
    logic                        wave_hit;
    logic                        ctrl_hit;
    logic                        def_hit;
    logic [3:0]                  nib;
    logic [2:0]                  wch;
    logic [2:0]                  vch;

    assign cur_per    = per_reg[cmd.ch];
    assign cnt_sum    = wsg_pkg::CntW'(phase_reg[cmd.ch]) + wsg_pkg::CntW'(tps_reg);
    assign sts.active = enable_reg[cmd.ch] && (cur_per != '0);
    assign sts.need_div = cnt_sum > wsg_pkg::CntW'(cur_per);

    assign shifted = {rem_reg, quo_reg[wsg_pkg::CntW-1]};
    assign sub_ok  = shifted >= {1'b0, cur_per};

    assign wave_hit = addr_reg[15:7] == wsg_pkg::WaveRegion;
    assign ctrl_hit = addr_reg[15:5] == wsg_pkg::CtrlRegion;
    assign def_hit  = addr_reg[15:5] == wsg_pkg::DefRegion;
    assign nib      = addr_reg[3:0];
    assign wch      = nib[3:1];
    assign vch      = 3'(nib - wsg_pkg::VolBase);

    // Channel five shares the fourth waveform
    assign rd_addr   = {(cmd.ch == wsg_pkg::LastCh) ? 2'd3 : cmd.ch[1:0], pos_reg[cmd.ch]};
    assign wave_byte = rvld_reg ? rdata_reg : wsg_pkg::WaveReset;
    assign product   = wave_byte * vol_reg[cmd.ch];
    assign sample    = out_reg;

    // Capture the bus transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
    end

    // Tick register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= wsg_pkg::TpsReset;
        end
        else if (cfg_we)
        begin
            tps_reg <= cfg_wdata;
        end
    end

    // Channel registers: bus writes and per-tick phase update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumCh; i++)
            begin
                per_reg[i]   <= '0;
                vol_reg[i]   <= '0;
                pos_reg[i]   <= '0;
                phase_reg[i] <= '0;
            end
            enable_reg <= '0;
            deform_reg <= '0;
        end
        else if (cmd.bus_wr)
        begin
            if (ctrl_hit)
            begin
                if (nib < wsg_pkg::VolBase)
                begin
                    if (nib[0])
                    begin
                        per_reg[wch][11:8] <= data_reg[3:0];
                    end
                    else
                    begin
                        per_reg[wch][7:0] <= data_reg;
                    end
                    if (deform_reg[5])
                    begin
                        pos_reg[wch] <= '0;
                    end
                end
                else if (nib == wsg_pkg::EnableReg)
                begin
                    enable_reg <= data_reg;
                end
                else
                begin
                    vol_reg[vch] <= {data_reg[3:0], 2'b00};
                end
            end
            else if (def_hit)
            begin
                deform_reg <= data_reg;
            end
        end
        else if (cmd.update)
        begin
            if (div_used_reg)
            begin
                pos_reg[cmd.ch]   <= pos_reg[cmd.ch] + quo_reg[4:0];
                phase_reg[cmd.ch] <= wsg_pkg::PhaseW'(rem_reg);
            end
            else
            begin
                phase_reg[cmd.ch] <= cnt_reg[wsg_pkg::PhaseW-1:0];
            end
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg      <= cnt_sum;
            quo_reg      <= cnt_sum;
            rem_reg      <= '0;
            div_used_reg <= sts.need_div;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= sub_ok ? wsg_pkg::PerW'(shifted - {1'b0, cur_per})
                              : shifted[wsg_pkg::PerW-1:0];
            quo_reg <= {quo_reg[wsg_pkg::CntW-2:0], sub_ok};
        end
    end

    // Wave memory
    always_ff @(posedge clk)
    begin
        if (cmd.bus_wr && wave_hit)
        begin
            wave_mem[addr_reg[6:0]] <= data_reg;
        end
        if (cmd.rd)
        begin
            rdata_reg <= wave_mem[rd_addr];
        end
    end

    // Written flags: unwritten bytes read as the reset pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_vld_reg <= '0;
            rvld_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.bus_wr && wave_hit)
            begin
                wave_vld_reg[addr_reg[6:0]] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rvld_reg <= wave_vld_reg[rd_addr];
            end
        end
    end

    // Accumulate the mix and hold the finished sample
    always_ff @(posedge clk)
    begin
        if (cmd.clr_sum)
        begin
            sum_reg <= '0;
        end
        else if (cmd.mac)
        begin
            sum_reg <= sum_reg + wsg_pkg::SumW'(product);
        end
        if (cmd.publish)
        begin
            out_reg <= sum_reg;
        end
    end

endmodule

FILE: src/wavetable_sound_generator_5ch.sv
// ----------------------------------------------------------------------------
// wavetable_sound_generator_5ch
// Five-channel wavetable generator: bus writes in, one mixed sample per tick.
// ----------------------------------------------------------------------------
// Bus write transaction: a write state after accept, then ready returns. Sample tick:
// each active channel steps load, update, read and mac, plus the shared divider
// (one bit per cycle) between load and update when the count is above the period;
// an idle channel takes only load. Publish waits for a free output register, then
// sample and ready come together; the sample waits while the next transaction is taken.
// Reset (rst_n, async low): all channel state zero, tick register 81, waves read 0xFF.

module wavetable_sound_generator_5ch
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] address, [23:16] data
    input  logic        s_tuser,    // [0] command: 0 bus write, 1 sample tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [16:0] sample, [23:17] zero
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    wsg_pkg::ctrl_cmd_t         cmd;
    wsg_pkg::dp_sts_t           sts;
    logic [wsg_pkg::SumW-1:0]   sample;

    wsg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd),
        .sts      (sts)
    );

    wsg_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .sample    (sample)
    );

    assign m_tdata = {7'b0, sample};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives bus writes and sample ticks into the five-channel wavetable generator.
// A behavioral mixer model predicts each sample, and a scoreboard checks the
// samples in order.
// ----------------------------------------------------------------------------

class sample_scoreboard;
    logic [7:0]  wave_mem [128];
    logic [11:0] period [5];
    logic [5:0]  volume [5];
    logic [4:0]  position [5];
    logic [13:0] phase [5];
    logic [7:0]  enables;
    logic [7:0]  deform;
    logic [11:0] tick_step;
    logic [16:0] pending_samples [$];
    int          errors;

    function void clear_state();
        for (int i = 0; i < 128; i++) wave_mem[i] = 8'hFF;
        for (int c = 0; c < 5; c++)
        begin
            period[c] = '0;
            volume[c] = '0;
            position[c] = '0;
            phase[c] = '0;
        end
        enables = '0;
        deform = '0;
        tick_step = 12'd81;
        errors = 0;
    endfunction

    function logic [16:0] mix_sample();
        int unsigned sum;
        int unsigned cnt;
        int unsigned base;
        sum = 0;
        for (int c = 0; c < 5; c++)
        begin
            if (enables[c] && period[c] != 0)
            begin
                base = (c < 4) ? c * 32 : 96;
                cnt = phase[c] + tick_step;
                if (cnt > period[c])
                begin
                    position[c] = 5'(position[c] + cnt / period[c]);
                    cnt = cnt % period[c];
                end
                phase[c] = 14'(cnt);
                sum += wave_mem[7'(base + position[c])] * volume[c];
            end
        end
        return 17'(sum);
    endfunction

    // Note one accepted transaction; a tick queues its predicted sample.
    function void note_input(logic cmd, logic [15:0] addr, logic [7:0] dat);
        int n;
        if (cmd)
        begin
            pending_samples.push_back(mix_sample());
            return;
        end
        if (addr >= 16'h9800 && addr < 16'h9880)
            wave_mem[addr[6:0]] = dat;
        else if (addr >= 16'h9880 && addr < 16'h98A0)
        begin
            n = int'(addr[3:0]);
            if (n < 10)
            begin
                if (n % 2 == 0) period[n/2][7:0] = dat;
                else period[n/2][11:8] = dat[3:0];
                if (deform[5]) position[n/2] = '0;
            end
            else if (n < 15) volume[n-10] = {dat[3:0], 2'b00};
            else enables = dat;
        end
        else if (addr >= 16'h98E0 && addr < 16'h9900)
            deform = dat;
    endfunction

    function void check_sample(logic [23:0] got);
        logic [23:0] want;
        if (pending_samples.size() == 0)
        begin
            $display("%0t: unexpected sample, expected none, actual %0d", $time, got);
            errors++;
            return;
        end
        want = {7'b0, pending_samples.pop_front()};
        if (got !== want)
        begin
            $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        cfg_we = 0;
    logic [11:0] cfg_wdata = '0;
    int          hold_off = 0;
    int          burst_left = 0;
    sample_scoreboard sb;

    wavetable_sound_generator_5ch DUT (.*);

    always #1 clk = ~clk;

    // Check every result transaction at the rising edge.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check_sample(m_tdata);

    // Receiver stall pattern, with a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Offer one transaction and hold it until accepted; gaps between bursts.
    // Valid stays high after the accept until the next item or an idle gap.
    task automatic send(logic cmd, logic [15:0] addr, logic [7:0] dat);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {dat, addr};
        do @(posedge clk); while (!s_tready);
        sb.note_input(cmd, addr, dat);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_samples.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_step(logic [11:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.tick_step = v;
    endtask

    task automatic random_item();
        int r;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        if (r < 35) send(1, 16'($urandom), 8'($urandom));
        else
        begin
            if (r < 55) a = 16'(16'h9800 + $urandom_range(0, 127));
            else if (r < 85) a = 16'(16'h9880 + $urandom_range(0, 31));
            else if (r < 92) a = 16'(16'h98E0 + $urandom_range(0, 31));
            else a = 16'($urandom);
            send(0, a, 8'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // Directed: default ticks on reset waves, then set up all channels.
        send(1, 16'h0000, 8'h00);
        send(0, 16'h988F, 8'hFF);
        send(1, 16'hFFFF, 8'hFF);
        for (int c = 0; c < 5; c++)
        begin
            send(0, 16'(16'h9880 + 2*c), 8'(10 + 20*c));
            send(0, 16'(16'h9891 + 2*c), 8'hF0);
            send(0, 16'(16'h988A + c), 8'hFF);
        end
        send(0, 16'h9800, 8'h00);
        send(0, 16'h987F, 8'hFF);
        send(0, 16'h98A5, 8'h12);
        send(0, 16'h98E0, 8'h20);
        send(1, 16'h0, 8'h0);
        send(0, 16'h9880, 8'h51);
        send(0, 16'h9880, 8'h00);
        send(1, 16'h0, 8'h0);
        set_step(12'd10);
        send(1, 16'h0, 8'h0);
        send(0, 16'h9880, 8'h0A);
        send(1, 16'h0, 8'h0);
        // Random phases across several tick settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_step(12'd1);
                1: set_step(12'd4095);
                2: set_step(12'd0);
                default: set_step(12'($urandom_range(1, 4095)));
            endcase
            for (int i = 0; i < 140; i++)
            begin
                if (ph == 3 && i == 20) hold_off = 300;
                if (ph == 4 && i == 50) drain();
                random_item();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end
endmodule

FILE: wavetable_sound_generator_5ch.f
+incdir+src
src/wsg_pkg.sv
src/wsg_ctrl.sv
src/wsg_datapath.sv
src/wavetable_sound_generator_5ch.sv
verif/tb.sv
